>>> rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent this cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/tcs_pkg.sv
package tcs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int CFG_W  = 9;
  localparam int IDX_W  = 3;
  localparam int SEL_W  = 2;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;

  // working width for signed position arithmetic
  localparam int POS_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CALC_W = ((POS_W > CFG_W) ? POS_W : CFG_W) + 2;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_SHIFT_X       = 3'd2,
    REG_SHIFT_Y       = 3'd3,
    REG_SOURCE_SELECT = 3'd4,
    REG_TARGET_SELECT = 3'd5
  } tcs_reg_e;

  typedef enum logic [SEL_W-1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } tcs_chan_e;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // effective configuration: dimensions clamped, shifts limited
  typedef struct packed {
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [CALC_W-1:0] shift_x;
    logic [CALC_W-1:0] shift_y;
    tcs_chan_e         src;
    tcs_chan_e         tgt;
  } tcs_cfg_t;

endpackage

>>> rtl/tcs_intf.sv
interface tcs_in_if;
  import tcs_pkg::*;

  logic            valid;
  logic            ready;
  logic            opcode;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, output opcode, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink   (input valid, input opcode, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

interface tcs_out_if;
  import tcs_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input frame_end, output ready);
endinterface

>>> rtl/pixel_ram.sv
module pixel_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 24,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

>>> rtl/tcs_cfg.sv
module tcs_cfg
  import tcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output tcs_cfg_t         cfg_o
);

  logic [CFG_W-1:0] width_q, height_q, shift_x_q, shift_y_q;
  logic [SEL_W-1:0] src_q, tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= CFG_W'(256);
      height_q  <= CFG_W'(256);
      shift_x_q <= '0;
      shift_y_q <= '0;
      src_q     <= '0;
      tgt_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (tcs_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:   width_q   <= cfg_wdata_i;
        REG_FRAME_HEIGHT:  height_q  <= cfg_wdata_i;
        REG_SHIFT_X:       shift_x_q <= cfg_wdata_i;
        REG_SHIFT_Y:       shift_y_q <= cfg_wdata_i;
        REG_SOURCE_SELECT: src_q     <= cfg_wdata_i[SEL_W-1:0];
        REG_TARGET_SELECT: tgt_q     <= cfg_wdata_i[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0]         w_eff, h_eff;
  logic signed [CALC_W-1:0] sx, sy, lim_x, lim_y;

  always_comb begin
    if (width_q == '0) begin
      w_eff = CFG_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = CFG_W'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end

    // limit to +/-(dim-1)
    lim_x = $signed(CALC_W'(w_eff)) - $signed(CALC_W'(1));
    lim_y = $signed(CALC_W'(h_eff)) - $signed(CALC_W'(1));
    sx    = CALC_W'($signed(shift_x_q));
    sy    = CALC_W'($signed(shift_y_q));
    if (sx > lim_x) begin
      sx = lim_x;
    end else if (sx < -lim_x) begin
      sx = -lim_x;
    end
    if (sy > lim_y) begin
      sy = lim_y;
    end else if (sy < -lim_y) begin
      sy = -lim_y;
    end

    cfg_o.width   = w_eff;
    cfg_o.height  = h_eff;
    cfg_o.shift_x = sx;
    cfg_o.shift_y = sy;
    cfg_o.src     = tcs_chan_e'(src_q);
    cfg_o.tgt     = tcs_chan_e'(tgt_q);
  end

endmodule

>>> rtl/tcs_addr.sv
module tcs_addr
  import tcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              opcode_i,
  input  tcs_cfg_t          cfg_i,
  output logic [ADDR_W-1:0] addr_o,
  output logic              last_o
);

  logic [COL_W-1:0] load_col_q, emit_col_q;
  logic [ROW_W-1:0] load_row_q, emit_row_q;

  logic [CALC_W-1:0]        c, r, c_nx, r_nx, wd, ht;
  logic signed [CALC_W-1:0] sx, sy;

  always_comb begin
    wd = CALC_W'(cfg_i.width);
    ht = CALC_W'(cfg_i.height);
    c  = (opcode_i == OP_EMIT) ? CALC_W'(emit_col_q) : CALC_W'(load_col_q);
    r  = (opcode_i == OP_EMIT) ? CALC_W'(emit_row_q) : CALC_W'(load_row_q);

    // counters left beyond a reduced frame restart on the next row
    if (c >= wd) begin
      c = '0;
      r = r + CALC_W'(1);
    end
    if (r >= ht) begin
      r = '0;
    end

    c_nx   = c + CALC_W'(1);
    r_nx   = r;
    last_o = 1'b0;
    if (c_nx >= wd) begin
      c_nx = '0;
      r_nx = r + CALC_W'(1);
      if (r_nx >= ht) begin
        r_nx   = '0;
        last_o = 1'b1;
      end
    end

    // single wrap is enough: |shift| < dim
    sx = $signed(c) + $signed(cfg_i.shift_x);
    if (sx >= $signed(wd)) sx = sx - $signed(wd);
    if (sx < 0)            sx = sx + $signed(wd);
    sy = $signed(r) + $signed(cfg_i.shift_y);
    if (sy >= $signed(ht)) sy = sy - $signed(ht);
    if (sy < 0)            sy = sy + $signed(ht);

    if (opcode_i == OP_EMIT) begin
      addr_o = ADDR_W'(sy[ROW_W-1:0] * MAX_WIDTH + sx[COL_W-1:0]);
    end else begin
      addr_o = ADDR_W'(r[ROW_W-1:0] * MAX_WIDTH + c[COL_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_col_q <= '0;
      load_row_q <= '0;
      emit_col_q <= '0;
      emit_row_q <= '0;
    end else if (fire_i) begin
      if (opcode_i == OP_EMIT) begin
        emit_col_q <= c_nx[COL_W-1:0];
        emit_row_q <= r_nx[ROW_W-1:0];
      end else begin
        load_col_q <= c_nx[COL_W-1:0];
        load_row_q <= r_nx[ROW_W-1:0];
      end
    end
  end

endmodule

>>> rtl/toroidal_channel_shift_unit.sv
// Emit items pass from the read stage into the output register; a stall can hold them in between.
// Load items give no result; they are written to the pixel store at the accepting edge.
// Throughput: one item per cycle while not stalled, set by the single port of the pixel store.
// The block stalls only while a result waits in both the read stage and the output register.
// Reset: raster counters to zero, valid flags and config to defaults; data and store not cleared.
`include "assert_macros.svh"

module toroidal_channel_shift_unit
  import tcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  tcs_in_if.sink           in_i,
  tcs_out_if.source        out_o
);

  tcs_cfg_t          cfg;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;
  logic              emit_last;
  logic              in_fire;
  logic              in_emit;

  logic              s1_valid_q, out_valid_q;
  logic              s1_adv;
  logic              s1_stall;
  logic [PIX_W-1:0]  s1_base_q;
  logic              s1_last_q;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign s1_stall   = s1_valid_q && !s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_emit    = in_fire && (in_i.opcode == OP_EMIT);

  tcs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tcs_addr u_addr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_fire),
    .opcode_i (in_i.opcode),
    .cfg_i    (cfg),
    .addr_o   (ram_addr),
    .last_o   (emit_last)
  );

  pixel_ram #(
    .DEPTH (DEPTH),
    .WIDTH (PIX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (in_fire),
    .we_i    (in_i.opcode == OP_LOAD),
    .addr_i  (ram_addr),
    .wdata_i ({in_i.red_in, in_i.green_in, in_i.blue_in}),
    .rdata_o (ram_rdata)
  );

  // channel replacement: source channel of the stored pixel into the target channel of the incoming pixel
  logic [CH_W-1:0] val;
  logic [CH_W-1:0] red_d, green_d, blue_d;

  always_comb begin
    case (cfg.src)
      CH_RED:   val = ram_rdata[PIX_W-1 -: CH_W];
      CH_GREEN: val = ram_rdata[2*CH_W-1 -: CH_W];
      CH_BLUE:  val = ram_rdata[CH_W-1:0];
      default:  val = '0;
    endcase
    red_d   = s1_base_q[PIX_W-1 -: CH_W];
    green_d = s1_base_q[2*CH_W-1 -: CH_W];
    blue_d  = s1_base_q[CH_W-1:0];
    case (cfg.tgt)
      CH_RED:   red_d   = val;
      CH_GREEN: green_d = val;
      CH_BLUE:  blue_d  = val;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_emit;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_emit) begin
      s1_base_q <= {in_i.red_in, in_i.green_in, in_i.blue_in};
      s1_last_q <= emit_last;
    end
    if (s1_adv && s1_valid_q) begin
      out_o.red_out   <= red_d;
      out_o.green_out <= green_d;
      out_o.blue_out  <= blue_d;
      out_o.frame_end <= s1_last_q;
    end
  end

  assign out_o.valid = out_valid_q;

  `ASSERT_NEXT(a_emit_fills_s1, clk_i, rst_ni, in_emit, s1_valid_q, "emit item lost")
  `ASSERT_NEXT(a_rd_hold, clk_i, rst_ni, s1_stall, s1_valid_q && $stable(ram_rdata), "rdata lost")
  `ASSERT_NEXT(a_s1_to_out, clk_i, rst_ni, s1_valid_q && s1_adv, out_valid_q, "s1 item stuck")

endmodule
